/* hw/rtl/tun_pkg.sv */
// Shared widths, opcodes and types of the triangle unit normal block.
`default_nettype none
package tun_pkg;
    localparam int COORD_W  = 20;
    localparam int IDX_W    = 10;
    localparam int NORM_W   = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int POS_W    = 6;
    localparam int MAG_W    = 31;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = ROOT_W + 2;
    localparam int QUO_W    = 16;
    localparam int DIV_W    = ROOT_W + 1;
    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TRI  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    typedef struct packed {
        logic       zero;
        logic [2:0] sgn;
    } tri_side_t;
endpackage
`default_nettype wire

/* hw/rtl/tun_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tun_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/tun_sqrt_cell.sv */
// One root bit of the pipelined integer square root.
`default_nettype none
module tun_sqrt_cell import tun_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [REM_W-1:0]  in_rem,
    input  wire logic [ROOT_W-1:0] in_root,
    input  wire logic [SUM_W-1:0]  in_s,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic      [REM_W-1:0]  out_rem,
    output logic      [ROOT_W-1:0] out_root,
    output logic      [SUM_W-1:0]  out_s,
    output logic      [SIDE_W-1:0] out_side
);
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W+1:0] rem_d;

    always_comb
    begin
        rem_sh = {in_rem, in_s[SUM_W-1 -: 2]};
        trial  = (REM_W+2)'({in_root, 2'b01});
        ge     = rem_sh >= trial;
        rem_d  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rem  <= rem_d[REM_W-1:0];
        out_root <= {in_root[ROOT_W-2:0], ge};
        out_s    <= {in_s[SUM_W-3:0], 2'b00};
        out_side <= in_side;
    end
endmodule
`default_nettype wire

/* hw/rtl/tun_div_cell.sv */
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module tun_div_cell import tun_pkg::*; (
    input  wire logic             clk,
    input  wire logic [DIV_W-1:0] in_rem,
    input  wire logic [DIV_W-1:0] in_d,
    input  wire logic [QUO_W-1:0] in_low,
    input  wire logic [QUO_W-1:0] in_q,
    output logic      [DIV_W-1:0] out_rem,
    output logic      [DIV_W-1:0] out_d,
    output logic      [QUO_W-1:0] out_low,
    output logic      [QUO_W-1:0] out_q
);
    logic [DIV_W:0] sh;
    logic           ge;
    logic [DIV_W:0] rem_d;

    always_comb
    begin
        sh    = {in_rem, in_low[QUO_W-1]};
        ge    = sh >= {1'b0, in_d};
        rem_d = ge ? sh - {1'b0, in_d} : sh;
    end

    always_ff @(posedge clk)
    begin
        out_rem <= rem_d[DIV_W-1:0];
        out_d   <= in_d;
        out_low <= {in_low[QUO_W-2:0], 1'b0};
        out_q   <= {in_q[QUO_W-2:0], ge};
    end
endmodule
`default_nettype wire

/* hw/rtl/triangle_unit_normal_top.sv */
// Top level: vertex store, cross product, normalize, square root and divide chains.
// Order: store read, front registers, root cells, divider setup and cells, output.
// Throughput: one item per cycle; busy is always low, set by the fully pipelined
// square root and divider cell chains and the triple-ported (replicated) store.
// Reset clears only the pipeline valid bits; the vertex store is undefined until loaded.
// The receiver cannot stall: each result is on the ports for the single cycle of done.
`default_nettype none
module triangle_unit_normal_top import tun_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      opcode,
    input  wire logic [IDX_W-1:0]          vertex_index,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    input  wire logic signed [COORD_W-1:0] coord_z,
    input  wire logic [IDX_W-1:0]          corner_a,
    input  wire logic [IDX_W-1:0]          corner_b,
    input  wire logic [IDX_W-1:0]          corner_c,
    output logic                           done,
    output logic signed [NORM_W-1:0]       normal_x,
    output logic signed [NORM_W-1:0]       normal_y,
    output logic signed [NORM_W-1:0]       normal_z,
    output logic                           degenerate
);
    localparam int AW     = $clog2(VERTEX_DEPTH);
    localparam int SIDE_W = 3 * MAG_W + $bits(tri_side_t);
    localparam int V_W    = $bits(vertex_t);

    logic          we;
    vertex_t       wvert;
    logic [IDX_W-1:0] corner [3];
    vertex_t       rvert [3];

    assign busy   = 1'b0;
    assign we     = start && (opcode == OP_LOAD) && (32'(vertex_index) < VERTEX_DEPTH);
    assign wvert  = '{z: coord_z, y: coord_y, x: coord_x};
    assign corner[0] = corner_a;
    assign corner[1] = corner_b;
    assign corner[2] = corner_c;

    for (genvar k = 0; k < 3; k++)
    begin : g_store
        tun_ram #(.WIDTH(V_W), .DEPTH(VERTEX_DEPTH)) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (AW'(vertex_index)),
            .wdata (wvert),
            .raddr (AW'(corner[k])),
            .rdata (rvert[k])
        );
    end

    // valid line of the front stages
    logic [7:0] v_reg;
    logic [2:0] inr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:0], start && (opcode == OP_TRI)};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            inr_reg[k] <= 32'(corner[k]) < VERTEX_DEPTH;
        end
    end

    // differences
    vertex_t                  pt [3];
    logic signed [DIFF_W-1:0] s1_reg [3];
    logic signed [DIFF_W-1:0] s2_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pt[k] = inr_reg[k] ? rvert[k] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg[0] <= {pt[0].x[COORD_W-1], pt[0].x} - {pt[1].x[COORD_W-1], pt[1].x};
        s1_reg[1] <= {pt[0].y[COORD_W-1], pt[0].y} - {pt[1].y[COORD_W-1], pt[1].y};
        s1_reg[2] <= {pt[0].z[COORD_W-1], pt[0].z} - {pt[1].z[COORD_W-1], pt[1].z};
        s2_reg[0] <= {pt[1].x[COORD_W-1], pt[1].x} - {pt[2].x[COORD_W-1], pt[2].x};
        s2_reg[1] <= {pt[1].y[COORD_W-1], pt[1].y} - {pt[2].y[COORD_W-1], pt[2].y};
        s2_reg[2] <= {pt[1].z[COORD_W-1], pt[1].z} - {pt[2].z[COORD_W-1], pt[2].z};
    end

    // cross product partial products
    logic signed [PROD_W-1:0] p_reg [6];

    always_ff @(posedge clk)
    begin
        p_reg[0] <= s1_reg[1] * s2_reg[2];
        p_reg[1] <= s1_reg[2] * s2_reg[1];
        p_reg[2] <= s1_reg[2] * s2_reg[0];
        p_reg[3] <= s1_reg[0] * s2_reg[2];
        p_reg[4] <= s1_reg[0] * s2_reg[1];
        p_reg[5] <= s1_reg[1] * s2_reg[0];
    end

    // magnitudes and signs
    logic signed [PROD_W-1:0] cr [3];
    logic [PROD_W-1:0]        mag_reg [3];
    logic [2:0]               sgn_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cr[k] = p_reg[2*k] - p_reg[2*k+1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[k] <= cr[k][PROD_W-1] ? PROD_W'(-cr[k]) : PROD_W'(cr[k]);
            sgn_reg[k] <= cr[k][PROD_W-1];
        end
    end

    // leading one of the largest magnitude
    logic [PROD_W-1:0] mor;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos_reg;
    logic [PROD_W-1:0] mag2_reg [3];
    tri_side_t         side4_reg;

    always_comb
    begin
        mor = mag_reg[0] | mag_reg[1] | mag_reg[2];
        pos = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (mor[i])
            begin
                pos = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos;
        mag2_reg       <= mag_reg;
        side4_reg.zero <= (mor == '0);
        side4_reg.sgn  <= sgn_reg;
    end

    // common shift to put the largest magnitude in [2^30, 2^31)
    logic [PROD_W-1:0] shv [3];
    logic [MAG_W-1:0]  mn_reg [3];
    tri_side_t         side5_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (pos_reg >= POS_W'(MAG_W - 1))
            begin
                shv[k] = mag2_reg[k] >> (pos_reg - POS_W'(MAG_W - 1));
            end
            else
            begin
                shv[k] = mag2_reg[k] << (POS_W'(MAG_W - 1) - pos_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mn_reg[k] <= shv[k][MAG_W-1:0];
        end
        side5_reg <= side4_reg;
    end

    // squares and sum
    logic [SQ_W-1:0]  sq_reg [3];
    logic [MAG_W-1:0] mn6_reg [3];
    tri_side_t        side6_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] mn7_reg [3];
    tri_side_t        side7_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= SQ_W'(mn_reg[k]) * SQ_W'(mn_reg[k]);
        end
        mn6_reg   <= mn_reg;
        side6_reg <= side5_reg;
        sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        mn7_reg   <= mn6_reg;
        side7_reg <= side6_reg;
    end

    // square root chain
    logic              sq_v    [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic [SUM_W-1:0]  sq_s    [ROOT_W+1];
    logic [SIDE_W-1:0] sq_side [ROOT_W+1];

    assign sq_v[0]    = v_reg[7];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_s[0]    = sum_reg;
    assign sq_side[0] = {mn7_reg[0], mn7_reg[1], mn7_reg[2], side7_reg};

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        tun_sqrt_cell #(.SIDE_W(SIDE_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_s      (sq_s[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_s     (sq_s[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // divider setup
    logic [MAG_W-1:0]       mr [3];
    tri_side_t              sr;
    logic [ROOT_W+QUO_W:0]  num [3];
    logic [DIV_W-1:0]       dv_rem [3][QUO_W+1];
    logic [DIV_W-1:0]       dv_d   [3][QUO_W+1];
    logic [QUO_W-1:0]       dv_low [3][QUO_W+1];
    logic [QUO_W-1:0]       dv_q   [3][QUO_W+1];
    logic                   dv_v_reg [QUO_W+1];
    tri_side_t              dv_side_reg [QUO_W+1];

    assign {mr[0], mr[1], mr[2], sr} = sq_side[ROOT_W];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num[k] = {2'b00, mr[k], QUO_W'(0)} + (ROOT_W+QUO_W+1)'(sq_root[ROOT_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_W; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dv_v_reg[0] <= sq_v[ROOT_W];
            for (int i = 1; i <= QUO_W; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            dv_rem[k][0] <= num[k][ROOT_W+QUO_W:QUO_W];
            dv_d[k][0]   <= {sq_root[ROOT_W], 1'b0};
            dv_low[k][0] <= num[k][QUO_W-1:0];
            dv_q[k][0]   <= '0;
        end
        dv_side_reg[0] <= sr;
        for (int i = 1; i <= QUO_W; i++)
        begin
            dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        for (genvar i = 0; i < QUO_W; i++)
        begin : g_div
            tun_div_cell u_cell (
                .clk     (clk),
                .in_rem  (dv_rem[k][i]),
                .in_d    (dv_d[k][i]),
                .in_low  (dv_low[k][i]),
                .in_q    (dv_q[k][i]),
                .out_rem (dv_rem[k][i+1]),
                .out_d   (dv_d[k][i+1]),
                .out_low (dv_low[k][i+1]),
                .out_q   (dv_q[k][i+1])
            );
        end
    end

    // clamp, sign and output register
    logic [QUO_W-1:0]  qc [3];
    logic [NORM_W-1:0] nv [3];
    tri_side_t         so;

    assign so = dv_side_reg[QUO_W];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qc[k] = (dv_q[k][QUO_W] > QUO_W'(32767)) ? QUO_W'(32767) : dv_q[k][QUO_W];
            if (so.zero)
            begin
                nv[k] = '0;
            end
            else
            begin
                nv[k] = so.sgn[k] ? NORM_W'(-qc[k]) : NORM_W'(qc[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= dv_v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        normal_x   <= nv[0];
        normal_y   <= nv[1];
        normal_z   <= nv[2];
        degenerate <= so.zero;
    end
endmodule
`default_nettype wire
